// File: sv/vprw_pkg.sv
package vprw_pkg;

   localparam int WINDOW_WORDS = 65536;
   localparam int ADDR_W       = $clog2(WINDOW_WORDS);
   localparam int PLANES       = 4;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 8;

   typedef enum logic {
      CMD_READ  = 1'b0,
      CMD_WRITE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      WMODE_0 = 2'd0,
      WMODE_1 = 2'd1,
      WMODE_2 = 2'd2,
      WMODE_3 = 2'd3
   } wmode_type;

   typedef enum logic [1:0] {
      ROP_REPLACE = 2'd0,
      ROP_AND     = 2'd1,
      ROP_OR      = 2'd2,
      ROP_XOR     = 2'd3
   } rop_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OPERATION_MODE   = 3'd0,
      REG_READ_PLANE       = 3'd1,
      REG_COLOUR_KEY       = 3'd2,
      REG_COLOUR_CARE      = 3'd3,
      REG_SET_RESET        = 3'd4,
      REG_ENABLE_SET_RESET = 3'd5,
      REG_BIT_MASK         = 3'd6,
      REG_PLANE_WRITE_MASK = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic                cmp_read;
      rop_type             rop;
      wmode_type           wmode;
      logic [1:0]          read_plane;
      logic [PLANES-1:0]   colour_key;
      logic [PLANES-1:0]   colour_care;
      logic [PLANES-1:0]   set_reset;
      logic [PLANES-1:0]   enable_set_reset;
      logic [7:0]          bit_mask;
      logic [PLANES-1:0]   plane_write_mask;
   } cfg_type;

   // controller -> datapath
   typedef struct packed {
      logic clr_step;
      logic wr_en;
      logic rd_en;
      logic rd_done;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_last;
   } dp_status_type;

endpackage

// File: sv/vga_planar_read_write_unit_top.sv
// Planar display memory read/write unit: four byte planes per 32-bit word,
// 64K words, with latch, set/reset, raster op, bit mask and plane mask.
// Request channel (req_valid/req_ready): req_cmd selects read or write,
// req_offset the word, req_write_data the host byte for writes.
// Response channel (rsp_valid/rsp_ready): one beat of rsp_read_data per read;
// writes give no beat.
// Register port: csr_we writes csr_wdata into register csr_index at the edge.
// Writes: one per cycle while the unit is idle, committed at the accepting edge.
// Reads: the memory word is registered at the accepting edge and passes to the
// response register from the read state once that register is free; req_ready
// stays low in the read state, so no new request is taken until the read is done.
// Reset: registers take their defaults and the latch clears, then a sweep
// zeroes all 65536 words of the plane memory one word a cycle, with req_ready low.
// Receiver stall: the response register holds its beat; further writes are
// still taken, and a following read waits with the word in hand until the
// response register frees.
module vga_planar_read_write_unit_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic [15:0]                         req_offset,
   input  logic [7:0]                          req_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_read_data,
   input  logic                                csr_we,
   input  logic [vprw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vprw_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   vprw_pkg::cfg_type        cfg;
   vprw_pkg::dp_cmd_type     dp_cmd;
   vprw_pkg::dp_status_type  dp_status;

   vprw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vprw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   vprw_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .dp_cmd         (dp_cmd),
      .dp_status      (dp_status),
      .req_offset     (req_offset),
      .req_write_data (req_write_data),
      .rsp_read_data  (rsp_read_data)
   );

endmodule

// File: sv/vprw_csr.sv
module vprw_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [vprw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vprw_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output vprw_pkg::cfg_type                   cfg
);

   vprw_pkg::cfg_type cfg_ff;
   vprw_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (vprw_pkg::reg_index_type'(csr_index))
            vprw_pkg::REG_OPERATION_MODE: begin
               cfg_in.cmp_read  = csr_wdata[4];
               cfg_in.rop       = vprw_pkg::rop_type'(csr_wdata[3:2]);
               cfg_in.wmode     = vprw_pkg::wmode_type'(csr_wdata[1:0]);
            end
            vprw_pkg::REG_READ_PLANE:       cfg_in.read_plane       = csr_wdata[1:0];
            vprw_pkg::REG_COLOUR_KEY:       cfg_in.colour_key       = csr_wdata[3:0];
            vprw_pkg::REG_COLOUR_CARE:      cfg_in.colour_care      = csr_wdata[3:0];
            vprw_pkg::REG_SET_RESET:        cfg_in.set_reset        = csr_wdata[3:0];
            vprw_pkg::REG_ENABLE_SET_RESET: cfg_in.enable_set_reset = csr_wdata[3:0];
            vprw_pkg::REG_BIT_MASK:         cfg_in.bit_mask         = csr_wdata[7:0];
            vprw_pkg::REG_PLANE_WRITE_MASK: cfg_in.plane_write_mask = csr_wdata[3:0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cmp_read         <= 1'b0;
         cfg_ff.rop              <= vprw_pkg::ROP_REPLACE;
         cfg_ff.wmode            <= vprw_pkg::WMODE_0;
         cfg_ff.read_plane       <= 2'd0;
         cfg_ff.colour_key       <= 4'h0;
         cfg_ff.colour_care      <= 4'hF;
         cfg_ff.set_reset        <= 4'h0;
         cfg_ff.enable_set_reset <= 4'h0;
         cfg_ff.bit_mask         <= 8'hFF;
         cfg_ff.plane_write_mask <= 4'hF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/vprw_ctrl.sv
module vprw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_cmd,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output vprw_pkg::dp_cmd_type     dp_cmd,
   input  vprw_pkg::dp_status_type  dp_status
);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_READ  = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      dp_cmd.clr_step = 1'b0;
      dp_cmd.wr_en    = 1'b0;
      dp_cmd.rd_en    = 1'b0;
      dp_cmd.rd_done  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            dp_cmd.clr_step = 1'b1;
            if (dp_status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (vprw_pkg::cmd_type'(req_cmd) == vprw_pkg::CMD_WRITE) begin
                  dp_cmd.wr_en = 1'b1;
               end else begin
                  dp_cmd.rd_en = 1'b1;
                  state_in     = ST_READ;
               end
            end
         end
         ST_READ: begin
            // hold the read word until the output register can take the beat
            if (out_free) begin
               dp_cmd.rd_done = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      if (dp_cmd.rd_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: sv/vprw_dp.sv
module vprw_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  vprw_pkg::cfg_type             cfg,
   input  vprw_pkg::dp_cmd_type          dp_cmd,
   output vprw_pkg::dp_status_type       dp_status,
   input  logic [15:0]                   req_offset,
   input  logic [7:0]                    req_write_data,
   output logic [7:0]                    rsp_read_data
);

   localparam int WORD_W = 8 * vprw_pkg::PLANES;

   logic [WORD_W-1:0]               plane_mem [vprw_pkg::WINDOW_WORDS];
   logic [WORD_W-1:0]               rdata_ff;
   logic [WORD_W-1:0]               latch_ff;
   logic [WORD_W-1:0]               latch_in;
   logic [vprw_pkg::ADDR_W-1:0]     clr_addr_ff;
   logic [vprw_pkg::ADDR_W-1:0]     clr_addr_in;
   logic [7:0]                      read_data_ff;
   logic [7:0]                      read_data_in;

   logic [vprw_pkg::ADDR_W-1:0]     acc_addr;
   logic [vprw_pkg::ADDR_W-1:0]     mem_waddr;
   logic [WORD_W-1:0]               mem_wdata;
   logic [vprw_pkg::PLANES-1:0]     mem_be;
   logic                            mem_we;

   logic [WORD_W-1:0]               bm;
   logic [WORD_W-1:0]               esr;
   logic [WORD_W-1:0]               sr;
   logic [WORD_W-1:0]               host_spread;
   logic [WORD_W-1:0]               wr_word;
   logic [WORD_W-1:0]               cmp_word;
   logic [7:0]                      cmp_byte;

   function automatic logic [WORD_W-1:0] plane_fill(input logic [vprw_pkg::PLANES-1:0] planes);
      logic [WORD_W-1:0] r;
      r = '0;
      for (int p = 0; p < vprw_pkg::PLANES; p++) begin
         r[8*p +: 8] = {8{planes[p]}};
      end
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] raster(input vprw_pkg::rop_type rop,
                                                input logic [WORD_W-1:0] data,
                                                input logic [WORD_W-1:0] mask,
                                                input logic [WORD_W-1:0] lat);
      logic [WORD_W-1:0] r;
      unique case (rop)
         vprw_pkg::ROP_REPLACE: r = (data & mask) | (lat & ~mask);
         vprw_pkg::ROP_AND:     r = (data | ~mask) & lat;
         vprw_pkg::ROP_OR:      r = (data & mask) | lat;
         vprw_pkg::ROP_XOR:     r = (data & mask) ^ lat;
         default:               r = lat;
      endcase
      return r;
   endfunction

   assign acc_addr    = req_offset[vprw_pkg::ADDR_W-1:0];
   assign bm          = {vprw_pkg::PLANES{cfg.bit_mask}};
   assign esr         = plane_fill(cfg.enable_set_reset);
   assign sr          = plane_fill(cfg.set_reset);
   assign host_spread = {vprw_pkg::PLANES{req_write_data}};

   always_comb begin
      unique case (cfg.wmode)
         vprw_pkg::WMODE_0:
            wr_word = raster(cfg.rop, (host_spread & ~esr) | (sr & esr), bm, latch_ff);
         vprw_pkg::WMODE_1:
            wr_word = latch_ff;
         vprw_pkg::WMODE_2:
            wr_word = raster(cfg.rop, plane_fill(req_write_data[3:0]), bm, latch_ff);
         vprw_pkg::WMODE_3:
            wr_word = raster(cfg.rop, sr, host_spread & bm, latch_ff);
         default:
            wr_word = latch_ff;
      endcase
   end

   // the clearing sweep takes the write port ahead of host writes
   always_comb begin
      if (dp_cmd.clr_step) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
         mem_be    = '1;
      end else begin
         mem_we    = dp_cmd.wr_en;
         mem_waddr = acc_addr;
         mem_wdata = wr_word;
         mem_be    = cfg.plane_write_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         for (int p = 0; p < vprw_pkg::PLANES; p++) begin
            if (mem_be[p]) begin
               plane_mem[mem_waddr][8*p +: 8] <= mem_wdata[8*p +: 8];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.rd_en) begin
         rdata_ff <= plane_mem[acc_addr];
      end
   end

   // colour compare: a bit is set where every compared plane matches
   assign cmp_word = (rdata_ff & plane_fill(cfg.colour_care))
                   ^ plane_fill(cfg.colour_key & cfg.colour_care);
   assign cmp_byte = ~(cmp_word[7:0] | cmp_word[15:8] | cmp_word[23:16] | cmp_word[31:24]);

   always_comb begin
      read_data_in = read_data_ff;
      latch_in     = latch_ff;
      if (dp_cmd.rd_done) begin
         latch_in = rdata_ff;
         if (cfg.cmp_read) begin
            read_data_in = cmp_byte;
         end else begin
            read_data_in = rdata_ff[8*cfg.read_plane +: 8];
         end
      end
   end

   assign clr_addr_in = dp_cmd.clr_step ? clr_addr_ff + 1'b1 : clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff    <= '0;
         clr_addr_ff <= '0;
      end else begin
         latch_ff    <= latch_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      read_data_ff <= read_data_in;
   end

   assign dp_status.clr_last = (clr_addr_ff == vprw_pkg::ADDR_W'(vprw_pkg::WINDOW_WORDS - 1));
   assign rsp_read_data      = read_data_ff;

endmodule
